FILE: hdl/nta_pkg.sv
// Shared types and constants for the nearest timestamp aligner.
package nta_pkg;
	localparam int TableDepth = 1024;
	localparam int IdxBits    = $clog2(TableDepth);
	localparam int TimeBits   = 31;
	localparam int CountBits  = 11;
	localparam int ObsBits    = 16;
	localparam int BurstBits  = 17;
	localparam int ValueBits  = 32;
	localparam int AddrBits   = 4;

	typedef logic [TimeBits-1:0]  time_t;
	typedef logic [IdxBits-1:0]   idx_t;
	typedef logic [ValueBits-1:0] value_t;

	typedef enum logic [1:0] {
		REG_REF_COUNT   = 2'd0,
		REG_TOL         = 2'd1,
		REG_OUTPUT_KIND = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_INDEX = 2'd0,
		KIND_DIFF  = 2'd1,
		KIND_BURST = 2'd2,
		KIND_SPARE = 2'd3
	} out_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_FRD,
		ST_FCAP,
		ST_DCAP,
		ST_EMIT_P,
		ST_EMIT_L,
		ST_UPD
	} state_t;
endpackage

FILE: hdl/nearest_timestamp_aligner_top.sv
// Top level of the nearest timestamp aligner: table memory, search sequencer and result logic.
// A load request (mode 0) writes both table copies and leaves busy low. An observation request
// binary-searches the table held in two mirrored registered-read memories; each search step
// passes through a read state and a compare state, and there are at most ceil(log2(n)) steps for
// n searched entries. Busy stays high through the search, the final read and capture states, the
// result of a still pending earlier observation, and the result or update of the current one.
// Each result is shown for one cycle with res_valid, and the receiver cannot stall it.
// The result of an observation leaves with the next observation, or with itself when it
// carries last_obs; if an earlier observation is pending, that request gives two results in consecutive cycles.
module nearest_timestamp_aligner_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nta_pkg::AddrBits-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [nta_pkg::TimeBits-1:0] time_value,
	input  logic [nta_pkg::IdxBits-1:0]  ref_index,
	input  logic                         last_obs,
	output logic                         res_valid,
	output logic [nta_pkg::ObsBits-1:0]  obs_index,
	output logic                         matched,
	output logic signed [nta_pkg::ValueBits-1:0] value,
	output logic                         last_of_run
);
	import nta_pkg::*;

	function automatic time_t abs_diff(input time_t a, input time_t b);
		abs_diff = (a >= b) ? a - b : b - a;
	endfunction

	// Configuration registers.
	logic [CountBits-1:0] ref_count_q;
	time_t                tol_q;
	logic [1:0]           kind_q;
	reg_idx_t             reg_sel;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= CountBits'(2);
			tol_q       <= '0;
			kind_q      <= KIND_INDEX;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_REF_COUNT:   ref_count_q <= pwdata[CountBits-1:0];
				REG_TOL:         tol_q       <= pwdata[TimeBits-1:0];
				REG_OUTPUT_KIND: kind_q      <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_REF_COUNT:   prdata = 32'(ref_count_q);
			REG_TOL:         prdata = 32'(tol_q);
			REG_OUTPUT_KIND: prdata = 32'(kind_q);
			default:         prdata = '0;
		endcase
	end

	// Sequencer and search registers.
	state_t state_q, state_d;
	idx_t   lo_q, hi_q, mid;
	time_t  t_q, rm_q, rp_q, r0_q, r1_q;
	logic   last_q;
	logic   accept;
	idx_t   hi_init;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign mid    = idx_t'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		if (ref_count_q == '0)
			hi_init = '0;
		else if (ref_count_q > CountBits'(TableDepth))
			hi_init = idx_t'(TableDepth - 1);
		else
			hi_init = idx_t'(ref_count_q - 1'b1);
	end

	// Two mirrored table copies give two reads per cycle.
	time_t mem_a [TableDepth];
	time_t mem_b [TableDepth];
	idx_t  rd_addr_a, rd_addr_b;
	time_t rd_a, rd_b;
	logic  mem_wr;

	assign mem_wr = accept && !mode;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_a[ref_index] <= time_value;
			mem_b[ref_index] <= time_value;
		end
		rd_a <= mem_a[rd_addr_a];
		rd_b <= mem_b[rd_addr_b];
	end

	// Pending observation and sequence state.
	time_t                prev_time_q, prev_prev_time_q, last_kept_q;
	idx_t                 prev_match_q;
	logic                 prev_matched_q, pend_valid_q, pp_valid_q, any_kept_q;
	logic [ObsBits-1:0]   obs_count_q;
	logic [BurstBits-1:0] burst_q;

	always_comb begin
		state_d   = state_q;
		rd_addr_a = mid;
		rd_addr_b = idx_t'(mid + 1'b1);
		unique case (state_q)
			ST_IDLE:   if (accept && mode) state_d = ST_SRD;
			ST_SRD:    state_d = (lo_q < hi_q) ? ST_SCMP : ST_FRD;
			ST_SCMP:   state_d = ST_SRD;
			ST_FRD: begin
				rd_addr_a = hi_q;
				rd_addr_b = prev_match_q;
				state_d   = ST_FCAP;
			end
			ST_FCAP: begin
				rd_addr_a = idx_t'(0);
				rd_addr_b = idx_t'(1);
				state_d   = ST_DCAP;
			end
			ST_DCAP: begin
				if (pend_valid_q) state_d = ST_EMIT_P;
				else if (last_q)  state_d = ST_EMIT_L;
				else              state_d = ST_UPD;
			end
			ST_EMIT_P: state_d = last_q ? ST_EMIT_L : ST_UPD;
			ST_EMIT_L: state_d = ST_IDLE;
			ST_UPD:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Keep decisions and result value.
	logic      mv, k_pend, k_last, emit_last, kept, step_hit;
	time_t     r_e, t_e;
	logic [ValueBits-1:0] step, diff;
	logic [BurstBits-1:0] burst_n;
	value_t    val_d;

	always_comb begin
		mv = abs_diff(t_q, rm_q) < tol_q;
		// The pending observation always has a next neighbor, the current one.
		if (prev_time_q < rp_q)
			k_pend = !(abs_diff(t_q, rp_q) < abs_diff(prev_time_q, rp_q));
		else if (!pp_valid_q)
			k_pend = 1'b1;
		else
			k_pend = !(abs_diff(prev_prev_time_q, rp_q) < abs_diff(prev_time_q, rp_q));
		k_pend = k_pend && prev_matched_q;
		if (t_q < rm_q || !pend_valid_q)
			k_last = 1'b1;
		else
			k_last = !(abs_diff(prev_time_q, rm_q) < abs_diff(t_q, rm_q));
		k_last = k_last && mv;

		emit_last = (state_q == ST_EMIT_L);
		kept      = emit_last ? k_last : k_pend;
		r_e       = emit_last ? rm_q : rp_q;
		t_e       = emit_last ? t_q : prev_time_q;
		step      = {1'b0, r1_q} - {1'b0, r0_q};
		diff      = {1'b0, r_e} - {1'b0, last_kept_q};
		step_hit  = (diff == step);
		burst_n   = (any_kept_q && !step_hit) ? burst_q + 1'b1 : burst_q;

		val_d = '1;
		if (kept) begin
			case (kind_q)
				KIND_DIFF:  val_d = {1'b0, r_e} - {1'b0, t_e};
				KIND_BURST: val_d = ValueBits'(burst_n);
				default:    val_d = ValueBits'(emit_last ? hi_q : prev_match_q);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			res_valid        <= 1'b0;
			prev_time_q      <= '0;
			prev_prev_time_q <= '0;
			prev_match_q     <= '0;
			prev_matched_q   <= 1'b0;
			pend_valid_q     <= 1'b0;
			pp_valid_q       <= 1'b0;
			obs_count_q      <= '0;
			burst_q          <= BurstBits'(1);
			last_kept_q      <= '0;
			any_kept_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_valid <= (state_q == ST_EMIT_P) || (state_q == ST_EMIT_L);
			// The end of a sequence clears the burst state, so only the pending result updates it.
			if (state_q == ST_EMIT_P && kept && kind_q == KIND_BURST) begin
				burst_q     <= burst_n;
				any_kept_q  <= 1'b1;
				last_kept_q <= r_e;
			end
			if (state_q == ST_EMIT_L) begin
				prev_time_q      <= '0;
				prev_prev_time_q <= '0;
				prev_match_q     <= '0;
				prev_matched_q   <= 1'b0;
				pend_valid_q     <= 1'b0;
				pp_valid_q       <= 1'b0;
				obs_count_q      <= '0;
				burst_q          <= BurstBits'(1);
				last_kept_q      <= '0;
				any_kept_q       <= 1'b0;
			end
			if (state_q == ST_UPD) begin
				prev_prev_time_q <= prev_time_q;
				pp_valid_q       <= pend_valid_q;
				prev_time_q      <= t_q;
				prev_match_q     <= hi_q;
				prev_matched_q   <= mv;
				pend_valid_q     <= 1'b1;
				obs_count_q      <= obs_count_q + 1'b1;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept && mode) begin
			t_q    <= time_value;
			last_q <= last_obs;
			lo_q   <= '0;
			hi_q   <= hi_init;
		end
		if (state_q == ST_SCMP) begin
			// Ties go to the later entry.
			if (abs_diff(rd_b, t_q) <= abs_diff(rd_a, t_q)) lo_q <= idx_t'(mid + 1'b1);
			else                                            hi_q <= mid;
		end
		if (state_q == ST_FCAP) begin
			rm_q <= rd_a;
			rp_q <= rd_b;
		end
		if (state_q == ST_DCAP) begin
			r0_q <= rd_a;
			r1_q <= rd_b;
		end
		if (state_q == ST_EMIT_P || state_q == ST_EMIT_L) begin
			obs_index   <= emit_last ? obs_count_q : obs_count_q - 1'b1;
			matched     <= kept;
			value       <= val_d;
			last_of_run <= emit_last;
		end
	end
endmodule

FILE: hdl/nta_checker.sv
// Port-level checker for the nearest timestamp aligner and its bind.
module nta_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 mode,
	input logic                                 res_valid,
	input logic                                 matched,
	input logic signed [nta_pkg::ValueBits-1:0] value,
	input logic                                 last_of_run
);
	a_unmatched_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !matched |-> value == -1)
		else $error("unmatched result without -1 value");

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_of_run |=> !res_valid)
		else $error("result after end of sequence");

	a_obs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode |=> busy)
		else $error("observation request did not make the block busy");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !mode |=> !busy && !res_valid)
		else $error("load request occupied the block or gave a result");
endmodule

bind nearest_timestamp_aligner_top nta_checker u_nta_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
	.res_valid(res_valid), .matched(matched), .value(value), .last_of_run(last_of_run)
);

FILE: dv/tb_nearest_timestamp_aligner_top.sv
// Self-checking testbench for the nearest timestamp aligner top level.
`timescale 1ns / 1ps

module tb_nearest_timestamp_aligner_top;
	import nta_pkg::*;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_OBS  = 1'b1;
	localparam int   SETTLE_CYCLES = 30;
	localparam int   STALL_LIMIT   = 3000;
	localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [15:0] obs_idx;
		logic        hit;
		logic [31:0] val;
		logic        last;
	} align_res_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [AddrBits-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy, mode, last_obs;
	logic [TimeBits-1:0] time_value;
	logic [IdxBits-1:0] ref_index;
	logic res_valid, matched, last_of_run;
	logic [ObsBits-1:0] obs_index;
	logic signed [ValueBits-1:0] value;

	nearest_timestamp_aligner_top u_top (.*);

	// Predictor state: table, registers and the pending observation.
	logic [30:0] ref_times [0:TableDepth-1];
	logic [10:0] cfg_count;
	logic [30:0] cfg_tol;
	logic [1:0]  cfg_kind;
	logic [30:0] pend_time, pend_prev_time, kept_ref_time;
	int          pend_near;
	bit          pend_hit, pend_live, pend_prev_live, any_kept;
	logic [15:0] obs_cnt;
	logic [16:0] burst_no;

	align_res_t expected_results [$];
	int mismatches;
	int idle_pct;
	int quiet_cycles;
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint tdist(longint a, longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic int table_span();
		if (cfg_count == 0) return 1;
		if (cfg_count > TableDepth) return TableDepth;
		return int'(cfg_count);
	endfunction

	function automatic int nearest_ref(logic [30:0] t);
		int lo, hi, mid;
		lo = 0;
		hi = table_span() - 1;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (tdist(ref_times[mid+1], t) <= tdist(ref_times[mid], t)) lo = mid + 1;
			else hi = mid;
		end
		return hi;
	endfunction

	function automatic bit keeps(logic [30:0] t, int m, bit has_prev, logic [30:0] p,
		bit has_next, logic [30:0] nx);
		longint r, dc;
		r = ref_times[m];
		dc = tdist(t, r);
		if (t < r) return !has_next || !(tdist(nx, r) < dc);
		return !has_prev || !(tdist(p, r) < dc);
	endfunction

	function automatic void push_result(logic [15:0] idx, bit kept, int m, logic [30:0] t,
		bit last);
		align_res_t res;
		longint r, v, step;
		v = -1;
		if (kept) begin
			r = ref_times[m];
			if (cfg_kind == KIND_DIFF) begin
				v = r - longint'(t);
			end else if (cfg_kind == KIND_BURST) begin
				step = longint'(ref_times[1]) - longint'(ref_times[0]);
				if (any_kept && (r - longint'(kept_ref_time) != step))
					burst_no = burst_no + 17'd1;
				any_kept = 1'b1;
				kept_ref_time = r[30:0];
				v = longint'(burst_no);
			end else begin
				v = longint'(m);
			end
		end
		res.obs_idx = idx;
		res.hit = kept;
		res.val = v[31:0];
		res.last = last;
		expected_results.push_back(res);
	endfunction

	function automatic void clear_sequence();
		pend_time = '0; pend_prev_time = '0; pend_near = 0; pend_hit = 1'b0;
		obs_cnt = '0; burst_no = 17'd1; kept_ref_time = '0; any_kept = 1'b0;
		pend_live = 1'b0; pend_prev_live = 1'b0;
	endfunction

	function automatic void align_observation(logic [30:0] t, bit last);
		int m;
		bit hit;
		m = nearest_ref(t);
		hit = tdist(t, ref_times[m]) < longint'(cfg_tol);
		if (pend_live)
			push_result(obs_cnt - 16'd1, pend_hit && keeps(pend_time, pend_near,
				pend_prev_live, pend_prev_time, 1'b1, t), pend_near, pend_time, 1'b0);
		if (last) begin
			push_result(obs_cnt, hit && keeps(t, m, pend_live, pend_time, 1'b0, '0), m, t,
				1'b1);
			clear_sequence();
		end else begin
			pend_prev_time = pend_time;
			pend_prev_live = pend_live;
			pend_time = t;
			pend_near = m;
			pend_hit = hit;
			pend_live = 1'b1;
			obs_cnt = obs_cnt + 16'd1;
		end
	endfunction

	// Result checker: every strobe must match the oldest expected result.
	always @(posedge clk) begin
		align_res_t exp_res;
		if (arst_n && res_valid) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: obs_index=%0d matched=%0b value=%0d last=%0b",
						obs_index, matched, value, last_of_run);
			end else begin
				exp_res = expected_results.pop_front();
				if (obs_index !== exp_res.obs_idx || matched !== exp_res.hit ||
					value !== exp_res.val || last_of_run !== exp_res.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected idx=%0d m=%0b v=%0d l=%0b, got idx=%0d m=%0b v=%0d l=%0b",
							exp_res.obs_idx, exp_res.hit, $signed(exp_res.val), exp_res.last,
							obs_index, matched, value, last_of_run);
				end
			end
		end
	end

	// Watchdog over cycles in which neither a request nor a result is accepted.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || res_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_item(logic md, logic [30:0] t, logic [9:0] ix, logic lst);
		mode <= md;
		time_value <= t;
		ref_index <= ix;
		last_obs <= lst;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (md == MODE_LOAD) ref_times[ix] = t;
		else align_observation(t, lst);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_REF_COUNT: cfg_count = d[10:0];
			REG_TOL: cfg_tol = d[30:0];
			REG_OUTPUT_KIND: cfg_kind = d[1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [10:0] cnt, logic [30:0] tl, logic [1:0] kind);
		drain();
		write_reg(REG_REF_COUNT, {21'd0, cnt});
		write_reg(REG_TOL, {1'b0, tl});
		write_reg(REG_OUTPUT_KIND, {30'd0, kind});
	endtask

	// Ascending table, mostly on a fixed step so that burst numbers both hold and advance.
	task automatic load_table(int n, longint base, longint step);
		longint t;
		t = base;
		for (int i = 0; i < n; i++) begin
			if (t > TIME_MAX) t = TIME_MAX;
			send_item(MODE_LOAD, t[30:0], i[9:0], 1'($urandom_range(1)));
			t += ($urandom_range(9) == 0) ? step + $urandom_range(1, 3) * step : step;
		end
	endtask

	task automatic test_directed();
		load_table(8, 1000, 100);
		send_item(MODE_LOAD, 31'd1500, 10'd5, 1'b0);
		configure(11'd8, 31'd30, KIND_INDEX);
		// Ties go to the later entry; neighbors on both sides compete for a reference.
		send_item(MODE_OBS, 31'd0, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd990, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd995, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1050, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1110, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1120, 10'd0, 1'b0);
		send_item(MODE_OBS, TIME_MAX, 10'd0, 1'b1);
		send_item(MODE_OBS, 31'd1200, 10'd0, 1'b1);
		configure(11'd8, 31'd30, KIND_DIFF);
		send_item(MODE_OBS, 31'd1005, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1195, 10'd0, 1'b1);
		configure(11'd8, 31'd60, KIND_BURST);
		send_item(MODE_OBS, 31'd1000, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1100, 10'd0, 1'b0);
		send_item(MODE_OBS, 31'd1300, 10'd0, 1'b0);
		send_item(MODE_LOAD, 31'd1395, 10'd4, 1'b1);
		send_item(MODE_OBS, 31'd1400, 10'd0, 1'b1);
		configure(11'd0, 31'd0, KIND_SPARE);
		send_item(MODE_OBS, 31'd1000, 10'd0, 1'b1);
		configure(11'd2, TIME_MAX, KIND_SPARE);
		send_item(MODE_OBS, 31'd5, 10'd0, 1'b0);
		send_item(MODE_OBS, TIME_MAX, 10'd0, 1'b1);
	endtask

	task automatic test_full_table();
		configure(11'd2, 31'd0, KIND_INDEX);
		load_table(TableDepth, $urandom_range(0, 1000), 2000000);
		configure(11'h7FF, 31'd1500000, KIND_INDEX);
		send_item(MODE_OBS, 31'd0, 10'd0, 1'b0);
		send_item(MODE_OBS, ref_times[512], 10'd0, 1'b0);
		send_item(MODE_OBS, ref_times[1023] - 31'd7, 10'd0, 1'b0);
		send_item(MODE_OBS, TIME_MAX, 10'd0, 1'b1);
		configure(11'd1024, TIME_MAX, KIND_DIFF);
		send_item(MODE_OBS, ref_times[1023], 10'd0, 1'b1);
	endtask

	task automatic run_sequences(int items);
		int sent, len, k, n;
		longint t, prev_t, span;
		sent = 0;
		n = table_span();
		span = (cfg_tol < 16) ? 16 : longint'(cfg_tol);
		while (sent < items) begin
			len = $urandom_range(1, 12);
			k = $urandom_range(0, n - 1);
			prev_t = 0;
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(19) == 0) begin
					t = $urandom_range(0, n - 1);
					send_item(MODE_LOAD, 31'(ref_times[t] + $urandom_range(0, 3)), t[9:0],
						1'($urandom_range(1)));
				end
				if ($urandom_range(11) == 0) begin
					t = $urandom() & TIME_MAX;
				end else begin
					k = k + $urandom_range(0, 2);
					if (k > n - 1) k = n - 1;
					t = longint'(ref_times[k]) + longint'($urandom()) % (2 * span + 1) - span;
					if (t < prev_t) t = prev_t + $urandom_range(0, 1);
				end
				if (t < 0) t = 0;
				if (t > TIME_MAX) t = TIME_MAX;
				prev_t = t;
				send_item(MODE_OBS, t[30:0], 10'($urandom()), j == len - 1);
				sent++;
			end
		end
	endtask

	task automatic test_random_phase(int pct);
		int n;
		logic [10:0] cnt;
		logic [30:0] tl;
		longint step;
		idle_pct = pct;
		for (int round = 0; round < 2; round++) begin
			n = $urandom_range(2, 40);
			step = $urandom_range(1, 4) * (64 << $urandom_range(0, 12));
			configure(cfg_count, cfg_tol, cfg_kind);
			load_table(n, ($urandom_range(3) == 0) ? TIME_MAX - n * step * 2 :
				$urandom_range(0, 1 << 20), step);
			case ($urandom_range(5))
				0: cnt = 11'd0;
				1: cnt = 11'h7FF;
				default: cnt = 11'(n);
			endcase
			case ($urandom_range(4))
				0: tl = 31'd0;
				1: tl = TIME_MAX;
				2: tl = 31'd1;
				default: tl = 31'(step / $urandom_range(1, 3));
			endcase
			configure(cnt, tl, 2'($urandom_range(0, 3)));
			run_sequences(60);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; mode = 1'b0; time_value = '0; ref_index = '0; last_obs = 1'b0;
		mismatches = 0; idle_pct = 0; timed_out = 1'b0;
		cfg_count = 11'd2; cfg_tol = '0; cfg_kind = KIND_INDEX;
		clear_sequence();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_phase(0);
		test_random_phase(62);
		test_random_phase(16);
		test_random_phase(0);
		drain();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
